FILE: hw/rtl/generational_handle_allocator_macros.svh
// assertion macros shared by the allocator checker
// no dependencies; taken in by `include
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_MACROS_SVH

// same-cycle implication, off during reset
`define GHA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// next-cycle implication, off during reset
`define GHA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

FILE: hw/rtl/gha_pkg.sv
// shared constants and types for the generational handle allocator
// no dependencies
package gha_pkg;

  localparam int SLOT_COUNT = 256;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int COUNT_W    = $clog2(SLOT_COUNT + 1);
  localparam int ID_W       = 16;
  localparam int GEN_W      = 32;
  localparam int NEW_ID_W   = 9;
  localparam int STATUS_W   = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_CREATED   = 2'd0,
    ST_DESTROYED = 2'd1,
    ST_IGNORED   = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic {
    OP_CREATE  = 1'b0,
    OP_DESTROY = 1'b1
  } op_t;

endpackage

FILE: hw/rtl/gha_if.sv
// command and result channels of the handle allocator
// depends on gha_pkg
interface gha_cmd_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [gha_pkg::ID_W-1:0]   handle_id;
  logic [gha_pkg::GEN_W-1:0]  handle_generation;

  modport source (output valid, output op, output handle_id, output handle_generation,
                  input ready);
  modport sink (input valid, input op, input handle_id, input handle_generation,
                output ready);
endinterface

interface gha_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [gha_pkg::STATUS_W-1:0]  status;
  logic [gha_pkg::NEW_ID_W-1:0]  new_id;
  logic [gha_pkg::GEN_W-1:0]     new_generation;

  modport source (output valid, output status, output new_id, output new_generation,
                  input ready);
  modport sink (input valid, input status, input new_id, input new_generation,
                output ready);
endinterface

FILE: hw/rtl/generational_handle_allocator.sv
// generational handle allocator: slot pool with lifo free stack and generation counts
// depends on gha_pkg and the channel interfaces in gha_if.sv
//
//  channel | dir | payload                                  | accepted when
//  cmd     | in  | op, handle_id, handle_generation         | cmd.valid && cmd.ready
//  rsp     | out | status, new_id, new_generation           | rsp.valid && rsp.ready
//
// a command is accepted in S_IDLE, which issues the memory reads; S_EXEC then compares,
// writes back the generation/stack memories and loads the result.
// a new command is not accepted until S_EXEC has loaded the result of the last one.
// a stalled result holds S_EXEC until the result register frees up.
// synchronous reset clears alive bits, stack top and fresh-slot count; no clearing pass.
module generational_handle_allocator (
  input  logic      clk,
  input  logic      rst,
  gha_cmd_if.sink   cmd,
  gha_rsp_if.source rsp
);

  typedef enum logic {S_IDLE, S_EXEC} state_t;
  typedef enum logic [1:0] {K_POP, K_FRESH, K_FULL, K_DESTROY} kind_t;

  // stack entries keep the generation so a pop needs no second read
  typedef struct packed {
    logic [gha_pkg::SLOT_W-1:0] slot;
    logic [gha_pkg::GEN_W-1:0]  gen;
  } stack_entry_t;

  logic [gha_pkg::GEN_W-1:0] gen_mem [gha_pkg::SLOT_COUNT];
  stack_entry_t              stk_mem [gha_pkg::SLOT_COUNT];

  state_t                       state;
  kind_t                        kind;
  logic [gha_pkg::SLOT_W-1:0]   slot;
  logic [gha_pkg::GEN_W-1:0]    hgen;
  logic                         ign;
  logic [gha_pkg::COUNT_W-1:0]  free_top;
  logic [gha_pkg::COUNT_W-1:0]  slots_in_use;
  logic [gha_pkg::SLOT_COUNT-1:0] alive;
  logic [gha_pkg::GEN_W-1:0]    gen_rd;
  stack_entry_t                 stk_rd;

  logic                         out_valid;
  logic [gha_pkg::STATUS_W-1:0] out_status;
  logic [gha_pkg::NEW_ID_W-1:0] out_id;
  logic [gha_pkg::GEN_W-1:0]    out_gen;

  logic                         accept;
  logic [gha_pkg::ID_W-1:0]     id_m1;
  logic [gha_pkg::SLOT_W-1:0]   dslot;
  logic [gha_pkg::SLOT_W-1:0]   pop_idx;
  logic                         bad_id;
  kind_t                        kind_next;

  logic                         go;
  logic                         kill;
  logic                         push_room;
  logic [gha_pkg::SLOT_W-1:0]   ex_slot;
  logic [gha_pkg::GEN_W-1:0]    ex_gen;
  logic                         gen_we;
  logic                         stk_we;
  logic [gha_pkg::STATUS_W-1:0] ex_status;

  assign cmd.ready          = (state == S_IDLE);
  assign accept             = cmd.valid && cmd.ready;
  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.new_id         = out_id;
  assign rsp.new_generation = out_gen;

  // decode of the incoming transaction
  assign id_m1   = cmd.handle_id - gha_pkg::ID_W'(1);
  assign dslot   = id_m1[gha_pkg::SLOT_W-1:0];
  assign pop_idx = gha_pkg::SLOT_W'(free_top - gha_pkg::COUNT_W'(1));
  assign bad_id  = (cmd.handle_id == '0) || (32'(cmd.handle_id) > 32'(slots_in_use));

  always_comb begin
    if (cmd.op == gha_pkg::OP_DESTROY) begin
      kind_next = K_DESTROY;
    end else if (free_top != '0) begin
      kind_next = K_POP;
    end else if (32'(slots_in_use) < gha_pkg::SLOT_COUNT) begin
      kind_next = K_FRESH;
    end else begin
      kind_next = K_FULL;
    end
  end

  // S_EXEC: compare and write back
  assign go        = (state == S_EXEC) && (!out_valid || rsp.ready);
  assign kill      = !ign && alive[slot] && (gen_rd == hgen);
  assign push_room = 32'(free_top) < gha_pkg::SLOT_COUNT;

  always_comb begin
    ex_slot   = slot;
    ex_gen    = '0;
    gen_we    = 1'b0;
    stk_we    = 1'b0;
    ex_status = gha_pkg::ST_IGNORED;
    case (kind)
      K_POP: begin
        ex_slot   = stk_rd.slot;
        ex_gen    = stk_rd.gen + gha_pkg::GEN_W'(1);
        gen_we    = go;
        ex_status = gha_pkg::ST_CREATED;
      end
      K_FRESH: begin
        ex_slot   = slots_in_use[gha_pkg::SLOT_W-1:0];
        ex_gen    = gha_pkg::GEN_W'(1);
        gen_we    = go;
        ex_status = gha_pkg::ST_CREATED;
      end
      K_FULL: begin
        ex_status = gha_pkg::ST_FULL;
      end
      K_DESTROY: begin
        stk_we    = go && kill && push_room;
        ex_status = kill ? gha_pkg::ST_DESTROYED : gha_pkg::ST_IGNORED;
      end
      default: begin
        ex_status = gha_pkg::ST_IGNORED;
      end
    endcase
  end

  // memories: read on accept, write in S_EXEC
  always_ff @(posedge clk) begin
    if (accept) begin
      gen_rd <= gen_mem[dslot];
      stk_rd <= stk_mem[pop_idx];
    end
    if (gen_we) begin
      gen_mem[ex_slot] <= ex_gen;
    end
    if (stk_we) begin
      stk_mem[free_top[gha_pkg::SLOT_W-1:0]] <= '{slot: slot, gen: hgen};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      free_top     <= '0;
      slots_in_use <= '0;
      alive        <= '0;
    end else begin
      // a new result loaded in the same cycle keeps valid high
      if (out_valid && rsp.ready && !go) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
            kind  <= kind_next;
            slot  <= dslot;
            hgen  <= cmd.handle_generation;
            ign   <= bad_id;
          end
        end
        S_EXEC: begin
          if (go) begin
            state      <= S_IDLE;
            out_valid  <= 1'b1;
            out_status <= ex_status;
            case (kind)
              K_POP: begin
                alive[ex_slot] <= 1'b1;
                free_top       <= free_top - gha_pkg::COUNT_W'(1);
                out_id         <= gha_pkg::NEW_ID_W'(ex_slot) + gha_pkg::NEW_ID_W'(1);
                out_gen        <= ex_gen;
              end
              K_FRESH: begin
                alive[ex_slot] <= 1'b1;
                slots_in_use   <= slots_in_use + gha_pkg::COUNT_W'(1);
                out_id         <= gha_pkg::NEW_ID_W'(ex_slot) + gha_pkg::NEW_ID_W'(1);
                out_gen        <= ex_gen;
              end
              K_DESTROY: begin
                out_id  <= '0;
                out_gen <= '0;
                if (kill) begin
                  alive[slot] <= 1'b0;
                  if (push_room) begin
                    free_top <= free_top + gha_pkg::COUNT_W'(1);
                  end
                end
              end
              default: begin
                out_id  <= '0;
                out_gen <= '0;
              end
            endcase
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/gha_checker.sv
// port-level checks for the generational handle allocator, bound to the top level
// depends on gha_pkg and generational_handle_allocator_macros.svh
`include "generational_handle_allocator_macros.svh"

module gha_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         cmd_valid,
  input logic                         cmd_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [gha_pkg::STATUS_W-1:0] rsp_status,
  input logic [gha_pkg::NEW_ID_W-1:0] rsp_new_id,
  input logic [gha_pkg::GEN_W-1:0]    rsp_new_generation
);

  logic                                                         created;
  logic                                                         empty_handle;
  logic [gha_pkg::STATUS_W+gha_pkg::NEW_ID_W+gha_pkg::GEN_W-1:0] rsp_payload;

  assign created      = (rsp_status == gha_pkg::ST_CREATED);
  assign empty_handle = (rsp_new_id == '0) && (rsp_new_generation == '0);
  assign rsp_payload  = {rsp_status, rsp_new_id, rsp_new_generation};

  // one command in flight: no accept straight after an accept
  `GHA_ASSERT_NEXT(a_one_in_flight, clk, rst, cmd_valid && cmd_ready, !cmd_ready)

  // a stalled result transaction keeps its payload
  `GHA_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

  // a created handle never carries the invalid id
  `GHA_ASSERT_IMPL(a_created_id, clk, rst, rsp_valid && created, rsp_new_id != '0)

  // every other result carries an empty handle
  `GHA_ASSERT_IMPL(a_empty_handle, clk, rst, rsp_valid && !created, empty_handle)

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (
  .clk                (clk),
  .rst                (rst),
  .cmd_valid          (cmd.valid),
  .cmd_ready          (cmd.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_status         (rsp.status),
  .rsp_new_id         (rsp.new_id),
  .rsp_new_generation (rsp.new_generation)
);

FILE: dv/generational_handle_allocator_tb.sv
// self-checking testbench for the generational handle allocator
// drives create/destroy commands and checks every response against a typed answer or a slot-pool predictor
// depends on gha_pkg, gha_if.sv and the generational_handle_allocator rtl
module generational_handle_allocator_tb;

  localparam int LONG_HOLD   = 150;
  localparam int N_DIRECTED  = 18;
  localparam int TAIL_CYCLES = 10;

  typedef struct {
    gha_pkg::status_t                status;
    logic [gha_pkg::NEW_ID_W-1:0]    new_id;
    logic [gha_pkg::GEN_W-1:0]       new_generation;
  } handle_rsp_t;

  typedef struct {
    gha_pkg::op_t                    op;
    logic [gha_pkg::ID_W-1:0]        id;
    logic [gha_pkg::GEN_W-1:0]       gen;
    bit                              typed;
    gha_pkg::status_t                status;
    logic [gha_pkg::NEW_ID_W-1:0]    new_id;
    logic [gha_pkg::GEN_W-1:0]       new_generation;
  } cmd_row_t;

  logic clk = 1'b0;
  logic rst;

  gha_cmd_if cmd ();
  gha_rsp_if rsp ();

  generational_handle_allocator dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predicted pool state
  logic [gha_pkg::GEN_W-1:0]  slot_gen    [gha_pkg::SLOT_COUNT];
  bit                         slot_live   [gha_pkg::SLOT_COUNT];
  logic [gha_pkg::SLOT_W-1:0] freed_slots [gha_pkg::SLOT_COUNT];
  int                         freed_top   = 0;
  int                         fresh_count = 0;

  handle_rsp_t pending_rsp [$];
  int          fail_count   = 0;
  bit          calm         = 1'b0;
  bit          hold_rsp_req = 1'b0;

  // directed commands; only the obvious answers are typed in
  cmd_row_t directed_rows [N_DIRECTED] = '{
    '{gha_pkg::OP_DESTROY, 16'd0,    32'd0,         1'b1, gha_pkg::ST_IGNORED,   9'd0, 32'd0},
    '{gha_pkg::OP_DESTROY, 16'd1,    32'd1,         1'b1, gha_pkg::ST_IGNORED,   9'd0, 32'd0},
    '{gha_pkg::OP_CREATE,  16'd0,    32'd0,         1'b1, gha_pkg::ST_CREATED,   9'd1, 32'd1},
    '{gha_pkg::OP_CREATE,  16'd0,    32'd0,         1'b1, gha_pkg::ST_CREATED,   9'd2, 32'd1},
    '{gha_pkg::OP_DESTROY, 16'd2,    32'd2,         1'b1, gha_pkg::ST_IGNORED,   9'd0, 32'd0},
    '{gha_pkg::OP_DESTROY, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, gha_pkg::ST_IGNORED,   9'd0, 32'd0},
    '{gha_pkg::OP_DESTROY, 16'd2,    32'd1,         1'b1, gha_pkg::ST_DESTROYED, 9'd0, 32'd0},
    '{gha_pkg::OP_DESTROY, 16'd2,    32'd1,         1'b1, gha_pkg::ST_IGNORED,   9'd0, 32'd0},
    '{gha_pkg::OP_CREATE,  16'd0,    32'd0,         1'b0, gha_pkg::ST_CREATED,   9'd0, 32'd0},
    '{gha_pkg::OP_DESTROY, 16'd1,    32'd1,         1'b1, gha_pkg::ST_DESTROYED, 9'd0, 32'd0},
    '{gha_pkg::OP_DESTROY, 16'd2,    32'd2,         1'b0, gha_pkg::ST_DESTROYED, 9'd0, 32'd0},
    '{gha_pkg::OP_CREATE,  16'd0,    32'd0,         1'b0, gha_pkg::ST_CREATED,   9'd0, 32'd0},
    '{gha_pkg::OP_CREATE,  16'd0,    32'd0,         1'b0, gha_pkg::ST_CREATED,   9'd0, 32'd0},
    '{gha_pkg::OP_CREATE,  16'd0,    32'd0,         1'b1, gha_pkg::ST_CREATED,   9'd3, 32'd1},
    '{gha_pkg::OP_DESTROY, 16'd3,    32'd0,         1'b1, gha_pkg::ST_IGNORED,   9'd0, 32'd0},
    '{gha_pkg::OP_DESTROY, 16'd257,  32'd1,         1'b1, gha_pkg::ST_IGNORED,   9'd0, 32'd0},
    '{gha_pkg::OP_CREATE,  16'hFFFF, 32'hFFFF_FFFF, 1'b1, gha_pkg::ST_CREATED,   9'd4, 32'd1},
    '{gha_pkg::OP_DESTROY, 16'd256,  32'd1,         1'b1, gha_pkg::ST_IGNORED,   9'd0, 32'd0}
  };

  // advances the predicted pool by one command and returns its response
  function automatic handle_rsp_t alloc_or_free(gha_pkg::op_t op,
                                                logic [gha_pkg::ID_W-1:0] id,
                                                logic [gha_pkg::GEN_W-1:0] gen);
    handle_rsp_t r;
    int          slot;
    r.status         = gha_pkg::ST_IGNORED;
    r.new_id         = '0;
    r.new_generation = '0;
    if (op == gha_pkg::OP_CREATE) begin
      if (freed_top > 0) begin
        freed_top--;
        slot = freed_slots[freed_top];
        slot_gen[slot] = slot_gen[slot] + 1;
      end else if (fresh_count < gha_pkg::SLOT_COUNT) begin
        slot = fresh_count;
        fresh_count++;
        slot_gen[slot] = 1;
      end else begin
        r.status = gha_pkg::ST_FULL;
        return r;
      end
      slot_live[slot]  = 1'b1;
      r.status         = gha_pkg::ST_CREATED;
      r.new_id         = gha_pkg::NEW_ID_W'(slot + 1);
      r.new_generation = slot_gen[slot];
    end else if (id != 0 && id <= fresh_count && slot_live[id-1] && slot_gen[id-1] == gen) begin
      slot_live[id-1] = 1'b0;
      if (freed_top < gha_pkg::SLOT_COUNT) begin
        freed_slots[freed_top] = gha_pkg::SLOT_W'(id - 1);
        freed_top++;
      end
      r.status = gha_pkg::ST_DESTROYED;
    end
    return r;
  endfunction

  // offers one command and waits for the transaction, then predicts its response
  task automatic send_cmd(input gha_pkg::op_t op, input logic [gha_pkg::ID_W-1:0] id,
                          input logic [gha_pkg::GEN_W-1:0] gen,
                          output handle_rsp_t predicted);
    cmd.valid             <= 1'b1;
    cmd.op                <= op;
    cmd.handle_id         <= id;
    cmd.handle_generation <= gen;
    do @(posedge clk); while (!(cmd.valid && cmd.ready));
    predicted = alloc_or_free(op, id, gen);
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // random command; destroys are mostly of live handles so the stack gets deep
  task automatic send_random(input int create_pct);
    handle_rsp_t               predicted;
    int                        live_slots [$];
    int                        dead_slots [$];
    int                        kind;
    int                        s;
    gha_pkg::op_t              op;
    logic [gha_pkg::ID_W-1:0]  id;
    logic [gha_pkg::GEN_W-1:0] gen;
    for (int i = 0; i < fresh_count; i++) begin
      if (slot_live[i]) live_slots = {live_slots, i};
      else dead_slots = {dead_slots, i};
    end
    id  = gha_pkg::ID_W'($urandom);
    gen = $urandom;
    if ($urandom_range(0, 99) < create_pct) begin
      op = gha_pkg::OP_CREATE;
    end else begin
      op   = gha_pkg::OP_DESTROY;
      kind = $urandom_range(0, 9);
      if (kind <= 5 && live_slots.size() > 0) begin
        s  = live_slots[$urandom_range(0, live_slots.size() - 1)];
        id = gha_pkg::ID_W'(s + 1);
        // stale generation: flip at least one bit
        gen = (kind == 5) ? (slot_gen[s] ^ ($urandom | 32'd1)) : slot_gen[s];
      end else if (kind == 6 && dead_slots.size() > 0) begin
        s   = dead_slots[$urandom_range(0, dead_slots.size() - 1)];
        id  = gha_pkg::ID_W'(s + 1);
        gen = slot_gen[s];
      end else if (kind == 8) begin
        id = gha_pkg::ID_W'($urandom_range(0, 65535));
      end else if (kind == 9) begin
        id  = gha_pkg::ID_W'(fresh_count + 1 + $urandom_range(0, 3));
        gen = 32'd1;
      end else begin
        id = '0;
      end
    end
    send_cmd(op, id, gen, predicted);
    pending_rsp = {pending_rsp, predicted};
  endtask

  initial begin
    handle_rsp_t predicted;
    handle_rsp_t typed_rsp;
    rst                   <= 1'b1;
    cmd.valid             <= 1'b0;
    cmd.op                <= gha_pkg::OP_CREATE;
    cmd.handle_id         <= '0;
    cmd.handle_generation <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_cmd(directed_rows[i].op, directed_rows[i].id, directed_rows[i].gen, predicted);
      if (directed_rows[i].typed) begin
        typed_rsp.status         = directed_rows[i].status;
        typed_rsp.new_id         = directed_rows[i].new_id;
        typed_rsp.new_generation = directed_rows[i].new_generation;
        pending_rsp = {pending_rsp, typed_rsp};
      end else begin
        pending_rsp = {pending_rsp, predicted};
      end
      sender_gap();
    end

    // fill well past the pool size so full responses show up
    repeat (650) begin
      send_random(85);
      sender_gap();
    end
    // drain: deep lifo reuse
    repeat (500) begin
      send_random(25);
      sender_gap();
    end
    // receiver holds off for a long while so the command side backs up
    hold_rsp_req = 1'b1;
    repeat (500) begin
      send_random(50);
      sender_gap();
    end
    calm = 1'b1;
    repeat (200) send_random(55);
    cmd.valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[generational_handle_allocator] OK");
    end else begin
      $display("[generational_handle_allocator] ERROR");
    end
    $finish;
  end

  // response side back-pressure
  initial begin
    rsp.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_rsp_req) begin
        hold_rsp_req = 1'b0;
        rsp.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else if ($urandom_range(0, 5) == 0) begin
        // stretch with no stalls
        rsp.ready <= 1'b1;
        repeat ($urandom_range(10, 60)) @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    handle_rsp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_rsp.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected response: status %0d id %0d gen %0d",
                   rsp.status, rsp.new_id, rsp.new_generation);
        end
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.status !== want.status || rsp.new_id !== want.new_id ||
            rsp.new_generation !== want.new_generation) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("response mismatch: expected status %0d id %0d gen %0d, got %0d %0d %0d",
                     want.status, want.new_id, want.new_generation,
                     rsp.status, rsp.new_id, rsp.new_generation);
          end
        end
      end
    end
  end

  // watchdog, several times the slowest legal run
  initial begin
    #(20 * 400000);
    $display("[generational_handle_allocator] ERROR");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/gha_pkg.sv
hw/rtl/gha_if.sv
hw/rtl/generational_handle_allocator.sv
hw/rtl/gha_checker.sv
dv/generational_handle_allocator_tb.sv
